// ----- design/usbcep_pkg.sv -----
`timescale 1ns / 1ps

package usbcep_pkg;

    // Function codes carried in the input kind field
    localparam logic [1:0] FUNC_RX     = 2'd0;
    localparam logic [1:0] FUNC_TXFREE = 2'd1;
    localparam logic [1:0] FUNC_BUSRST = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_VENDOR_ID      = 2'd0;
    localparam logic [1:0] REG_PRODUCT_ID     = 2'd1;
    localparam logic [1:0] REG_DEVICE_RELEASE = 2'd2;

    localparam logic [15:0] VENDOR_ID_RESET      = 16'h16C0;
    localparam logic [15:0] PRODUCT_ID_RESET     = 16'h05DF;
    localparam logic [15:0] DEVICE_RELEASE_RESET = 16'h0100;

    localparam logic [7:0] PID_DATA0          = 8'hC3;
    localparam logic [7:0] PID_DATA1          = 8'h4B;
    localparam logic [7:0] NO_MSG             = 8'hFF;
    localparam logic [7:0] DEV_DESC_LEN       = 8'd18;
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
    localparam logic [7:0] DESC_TYPE_DEVICE   = 8'd1;
    localparam logic [7:0] USB_BCD_LO         = 8'h10;
    localparam logic [7:0] USB_BCD_HI         = 8'h01;
    localparam logic [7:0] EP0_MAX_SIZE       = 8'd8;
    localparam logic [7:0] NUM_CONFIGS        = 8'd1;
    localparam logic [3:0] SETUP_LEN          = 4'd8;
    localparam logic [3:0] PKT_OVERHEAD       = 4'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Microprogram step addresses
    typedef logic [2:0] t_step;
    localparam t_step S_WAIT  = 3'd0;
    localparam t_step S_DISP  = 3'd1;
    localparam t_step S_SETUP = 3'd2;
    localparam t_step S_TXCHK = 3'd3;
    localparam t_step S_PID   = 3'd4;
    localparam t_step S_DATA  = 3'd5;
    localparam t_step S_CRCLO = 3'd6;
    localparam t_step S_CRCHI = 3'd7;

    typedef enum logic [2:0] {
        A_NONE, A_LATCH, A_DISP, A_SETUP, A_TXLOAD, A_DATA, A_TXEND
    } t_act;

    typedef enum logic [2:0] {
        E_NONE, E_PID, E_DATA, E_CRCLO, E_CRCHI
    } t_emit;

    typedef enum logic [2:0] {
        C_NEXT, C_GOTO, C_FUNC, C_NOMSG, C_ZNEXT, C_ZSTAY
    } t_cond;

    typedef struct packed {
        logic  ready;
        t_act  act;
        t_emit emit;
        t_cond cond;
        t_step target;
    } t_uop;

    typedef struct packed {
        t_step step;
        t_uop  uop;
        logic  fire;
    } t_ctl;

    typedef struct packed {
        logic [1:0] func;
        logic       setup_ok;
        logic       no_msg;
        logic       cnt_zero;
        logic       emit_ok;
    } t_stat;

    typedef struct packed {
        logic [1:0] func;
        logic       is_setup_token;
        logic [3:0] data_len;
        logic [7:0] request_type;
        logic [7:0] request_code;
        logic [7:0] value_low;
        logic [7:0] value_high;
        logic [7:0] length_low;
        logic [7:0] length_high;
    } t_item;

    // Control store: one word per step.
    function automatic t_uop ucode(input t_step s);
        t_uop u;
        u = '{ready: 1'b0, act: A_NONE, emit: E_NONE, cond: C_NEXT, target: S_WAIT};
        case (s)
            S_WAIT: begin
                u.ready = 1'b1;
                u.act   = A_LATCH;
            end
            S_DISP: begin
                u.act  = A_DISP;
                u.cond = C_FUNC;
            end
            S_SETUP: begin
                u.act  = A_SETUP;
                u.cond = C_GOTO;
            end
            S_TXCHK: begin
                u.act  = A_TXLOAD;
                u.cond = C_NOMSG;
            end
            S_PID: begin
                u.emit   = E_PID;
                u.cond   = C_ZNEXT;
                u.target = S_CRCLO;
            end
            S_DATA: begin
                u.emit   = E_DATA;
                u.act    = A_DATA;
                u.cond   = C_ZSTAY;
                u.target = S_CRCLO;
            end
            S_CRCLO: begin
                u.emit = E_CRCLO;
            end
            S_CRCHI: begin
                u.emit = E_CRCHI;
                u.act  = A_TXEND;
                u.cond = C_GOTO;
            end
            default: begin
                u.cond = C_GOTO;
            end
        endcase
        return u;
    endfunction

    function automatic logic [7:0] desc_byte(
        input logic [4:0]  idx,
        input logic [15:0] vid,
        input logic [15:0] pid,
        input logic [15:0] rel
    );
        logic [7:0] b;
        case (idx)
            5'd0:    b = DEV_DESC_LEN;
            5'd1:    b = DESC_TYPE_DEVICE;
            5'd2:    b = USB_BCD_LO;
            5'd3:    b = USB_BCD_HI;
            5'd7:    b = EP0_MAX_SIZE;
            5'd8:    b = vid[7:0];
            5'd9:    b = vid[15:8];
            5'd10:   b = pid[7:0];
            5'd11:   b = pid[15:8];
            5'd12:   b = rel[7:0];
            5'd13:   b = rel[15:8];
            5'd17:   b = NUM_CONFIGS;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // Reflected CRC16 over one byte, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- design/usbcep_seq.sv -----
`timescale 1ns / 1ps

module usbcep_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  usbcep_pkg::t_stat  i_stat,
    output usbcep_pkg::t_ctl   o_ctl
);
    import usbcep_pkg::*;

    t_step r_step;
    t_step n_step;
    t_step jump;
    t_uop  uop;
    logic  fire;

    assign uop = ucode(r_step);

    // A step completes when its input arrives or its byte has room to leave; other steps always complete.
    always_comb begin
        if (uop.ready) begin
            fire = i_in_valid;
        end else if (uop.emit != E_NONE) begin
            fire = i_stat.emit_ok;
        end else begin
            fire = 1'b1;
        end
    end

    always_comb begin
        case (uop.cond)
            C_NEXT:  jump = t_step'(r_step + 3'd1);
            C_GOTO:  jump = uop.target;
            C_FUNC: begin
                if (i_stat.func == FUNC_RX) begin
                    jump = i_stat.setup_ok ? S_SETUP : S_WAIT;
                end else if (i_stat.func == FUNC_TXFREE) begin
                    jump = S_TXCHK;
                end else begin
                    jump = S_WAIT;
                end
            end
            C_NOMSG: jump = i_stat.no_msg ? uop.target : t_step'(r_step + 3'd1);
            C_ZNEXT: jump = i_stat.cnt_zero ? uop.target : t_step'(r_step + 3'd1);
            C_ZSTAY: jump = i_stat.cnt_zero ? uop.target : r_step;
            default: jump = S_WAIT;
        endcase
    end

    assign n_step = fire ? jump : r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl = '{step: r_step, uop: uop, fire: fire};

endmodule

// ----- design/usbcep_dp.sv -----
`timescale 1ns / 1ps

module usbcep_dp #(
    parameter int MAX_PACKET = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  usbcep_pkg::t_ctl  i_ctl,
    input  usbcep_pkg::t_item i_item,
    input  logic [15:0]       i_vendor_id,
    input  logic [15:0]       i_product_id,
    input  logic [15:0]       i_device_release,
    input  logic              i_out_ready,
    output usbcep_pkg::t_stat o_stat,
    output logic              o_out_valid,
    output logic [7:0]        o_tx_byte,
    output logic              o_last,
    output logic [3:0]        o_packet_len,
    output logic [7:0]        o_pending_address,
    output logic [7:0]        o_configuration
);
    import usbcep_pkg::*;

    localparam int         CW   = $clog2(MAX_PACKET + 1);
    localparam logic [7:0] MAXP = 8'(MAX_PACKET);

    t_item          r_item;
    logic [7:0]     r_addr, n_addr;
    logic [7:0]     r_cfgv, n_cfgv;
    logic [7:0]     r_remaining, n_remaining;
    logic [4:0]     r_read_idx, n_read_idx;
    logic [7:0]     r_toggle, n_toggle;
    logic [CW-1:0]  r_count, n_count;
    logic [3:0]     r_plen, n_plen;
    logic           r_short, n_short;
    logic [15:0]    r_crc, n_crc;

    logic           r_out_valid;
    logic [7:0]     r_tx_byte;
    logic           r_last;
    logic [3:0]     r_oplen;
    logic [7:0]     r_oaddr;
    logic [7:0]     r_ocfg;

    logic [7:0]     want;
    logic [7:0]     data_byte;
    logic [15:0]    crc_next;
    logic [CW-1:0]  cnt_after;
    logic           std_req;
    logic [7:0]     reply;
    logic [7:0]     out_byte;
    logic           do_emit;

    assign want      = (r_remaining > MAXP) ? MAXP : r_remaining;
    assign data_byte = desc_byte(r_read_idx, i_vendor_id, i_product_id, i_device_release);
    assign crc_next  = crc_byte(r_crc, data_byte);
    assign cnt_after = (i_ctl.uop.act == A_DATA) ? r_count - CW'(1) : r_count;
    assign std_req   = (r_item.request_type[6:5] == 2'b00);

    // Reply length is clamped to wLength only when its high byte is zero.
    always_comb begin
        reply = (std_req && r_item.request_code == REQ_GET_DESCRIPTOR
                 && r_item.value_high == DESC_TYPE_DEVICE) ? DEV_DESC_LEN : 8'd0;
        if (r_item.length_high == 8'd0 && reply > r_item.length_low) begin
            reply = r_item.length_low;
        end
    end

    always_comb begin
        n_addr      = r_addr;
        n_cfgv      = r_cfgv;
        n_remaining = r_remaining;
        n_read_idx  = r_read_idx;
        n_toggle    = r_toggle;
        n_count     = r_count;
        n_plen      = r_plen;
        n_short     = r_short;
        n_crc       = r_crc;
        if (i_ctl.fire) begin
            case (i_ctl.uop.act)
                A_DISP: begin
                    if (r_item.func == FUNC_BUSRST) begin
                        n_addr = 8'd0;
                    end
                end
                A_SETUP: begin
                    n_toggle    = PID_DATA0;
                    n_remaining = reply;
                    if (std_req && r_item.request_code == REQ_SET_ADDRESS) begin
                        n_addr = r_item.value_low;
                    end
                    if (std_req && r_item.request_code == REQ_SET_CONFIG) begin
                        n_cfgv = r_item.value_low;
                    end
                    if (std_req && r_item.request_code == REQ_GET_DESCRIPTOR
                        && r_item.value_high == DESC_TYPE_DEVICE) begin
                        n_read_idx = 5'd0;
                    end
                end
                A_TXLOAD: begin
                    if (r_remaining != NO_MSG) begin
                        n_remaining = r_remaining - want;
                        n_toggle    = r_toggle ^ (PID_DATA0 ^ PID_DATA1);
                        n_count     = CW'(want);
                        n_plen      = want[3:0] + PKT_OVERHEAD;
                        n_short     = (want < MAXP);
                        n_crc       = CRC_INIT;
                    end
                end
                A_DATA: begin
                    n_read_idx = r_read_idx + 5'd1;
                    n_count    = cnt_after;
                    n_crc      = crc_next;
                end
                A_TXEND: begin
                    if (r_short) begin
                        n_remaining = NO_MSG;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= 8'd0;
            r_cfgv      <= 8'd0;
            r_remaining <= NO_MSG;
            r_read_idx  <= 5'd0;
            r_toggle    <= PID_DATA0;
        end else begin
            r_addr      <= n_addr;
            r_cfgv      <= n_cfgv;
            r_remaining <= n_remaining;
            r_read_idx  <= n_read_idx;
            r_toggle    <= n_toggle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire && i_ctl.uop.act == A_LATCH) begin
            r_item <= i_item;
        end
        r_count <= n_count;
        r_plen  <= n_plen;
        r_short <= n_short;
        r_crc   <= n_crc;
    end

    always_comb begin
        case (i_ctl.uop.emit)
            E_PID:   out_byte = r_toggle;
            E_DATA:  out_byte = data_byte;
            E_CRCLO: out_byte = ~r_crc[7:0];
            E_CRCHI: out_byte = ~r_crc[15:8];
            default: out_byte = 8'd0;
        endcase
    end

    assign do_emit = i_ctl.fire && (i_ctl.uop.emit != E_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_tx_byte <= out_byte;
            r_last    <= (i_ctl.uop.emit == E_CRCHI);
            r_oplen   <= r_plen;
            r_oaddr   <= r_addr;
            r_ocfg    <= r_cfgv;
        end
    end

    assign o_stat = '{
        func:     r_item.func,
        setup_ok: r_item.is_setup_token && (r_item.data_len == SETUP_LEN),
        no_msg:   (r_remaining == NO_MSG),
        cnt_zero: (cnt_after == '0),
        emit_ok:  !r_out_valid || i_out_ready
    };

    assign o_out_valid       = r_out_valid;
    assign o_tx_byte         = r_tx_byte;
    assign o_last            = r_last;
    assign o_packet_len      = r_oplen;
    assign o_pending_address = r_oaddr;
    assign o_configuration   = r_ocfg;

endmodule

// ----- design/usb_control_endpoint_responder.sv -----
`timescale 1ns / 1ps
// Channel     Direction  Handshake               Payload
// s_axis      in         i_s_tvalid / o_s_tready event: kind in tuser, SETUP bytes in tdata
// m_axis      out        o_m_tvalid / i_m_tready one IN packet byte, tlast on CRC high
// cfg         in         i_cfg_valid/o_cfg_ready descriptor ID register writes
//
// A transmit-free event with a message pending sends its packet one byte per cycle,
// while the output is not stalled, from the sequencer's emit steps.
// A SETUP request runs the wait, dispatch and setup steps; a transmit-free event with no
// message pending runs wait, dispatch and transmit check; others run wait and dispatch.
// Reset is synchronous; while it is low no request or register write is accepted.
// A stalled output holds the sequencer on its current emit step.

module usb_control_endpoint_responder #(
    parameter int MAX_PACKET = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [3:0] data_len, [11:4] request_type, [19:12] request_code, [27:20] value_low,
    // [35:28] value_high, [43:36] length_low, [51:44] length_high, [55:52] zero
    input  logic [55:0] i_s_tdata,
    // [1:0] func, [2] is_setup_token
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] tx_byte, [11:8] packet_len, [19:12] pending_address,
    // [27:20] configuration, [31:28] zero
    output logic [31:0] o_m_tdata,
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import usbcep_pkg::*;

    logic [15:0] r_vendor_id;
    logic [15:0] r_product_id;
    logic [15:0] r_device_release;

    t_ctl        ctl;
    t_stat       stat;
    t_item       item;
    logic [7:0]  tx_byte;
    logic [3:0]  packet_len;
    logic [7:0]  pending_address;
    logic [7:0]  configuration;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vendor_id      <= VENDOR_ID_RESET;
            r_product_id     <= PRODUCT_ID_RESET;
            r_device_release <= DEVICE_RELEASE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VENDOR_ID:      r_vendor_id      <= i_cfg_data;
                REG_PRODUCT_ID:     r_product_id     <= i_cfg_data;
                REG_DEVICE_RELEASE: r_device_release <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign item = '{
        func:           i_s_tuser[1:0],
        is_setup_token: i_s_tuser[2],
        data_len:       i_s_tdata[3:0],
        request_type:   i_s_tdata[11:4],
        request_code:   i_s_tdata[19:12],
        value_low:      i_s_tdata[27:20],
        value_high:     i_s_tdata[35:28],
        length_low:     i_s_tdata[43:36],
        length_high:    i_s_tdata[51:44]
    };

    assign o_s_tready = ctl.uop.ready & i_rst_n;

    usbcep_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    usbcep_dp #(
        .MAX_PACKET (MAX_PACKET)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .i_item            (item),
        .i_vendor_id       (r_vendor_id),
        .i_product_id      (r_product_id),
        .i_device_release  (r_device_release),
        .i_out_ready       (i_m_tready),
        .o_stat            (stat),
        .o_out_valid       (o_m_tvalid),
        .o_tx_byte         (tx_byte),
        .o_last            (o_m_tlast),
        .o_packet_len      (packet_len),
        .o_pending_address (pending_address),
        .o_configuration   (configuration)
    );

    assign o_m_tdata = {4'd0, configuration, pending_address, packet_len, tx_byte};

    // The CRC high byte closes the packet and returns the sequencer to its wait step.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.step == S_CRCHI && ctl.fire) |=> (ctl.step == S_WAIT && o_m_tvalid && o_m_tlast))
        else $error("packet end did not load the final byte");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (ctl.step == S_DISP))
        else $error("accepted request was not dispatched");

    // The data loop leaves for the CRC as soon as its byte count runs out.
    a_data_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.step == S_DATA && ctl.fire && stat.cnt_zero) |=> (ctl.step == S_CRCLO))
        else $error("data loop overran its byte count");

endmodule

// ----- tb/sv/usb_control_endpoint_responder_tb.sv -----
`timescale 1ns / 1ps

module usb_control_endpoint_responder_tb;
    import usbcep_pkg::*;

    localparam int EP0_PKT = 8;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_PER_PHASE = 72;

    localparam logic [1:0] FUNC_SPARE      = 2'd3;
    localparam logic [7:0] RT_STD_OUT      = 8'h00;
    localparam logic [7:0] RT_STD_IN       = 8'h80;
    localparam logic [7:0] RT_CLASS        = 8'h21;
    localparam logic [7:0] RT_VENDOR       = 8'hC0;
    localparam logic [7:0] DESC_TYPE_CONFIG = 8'd2;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic [3:0] plen;
        logic [7:0] addr;
        logic [7:0] cfgv;
    } t_tx_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata = '0;
    logic [2:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_VENDOR_ID;
    logic [15:0] i_cfg_data = '0;

    // Endpoint state as the testbench expects it to be.
    logic [15:0] ep_vid, ep_pid, ep_rel;
    logic [7:0]  pend_addr, conf_val, msg_left, data_pid;
    logic [4:0]  desc_pos;

    t_item    pending_requests[$];
    t_item    in_flight;
    t_tx_byte tx_due[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int errors = 0;
    int accepted = 0;
    int ignored_made = 0;
    int packets_due = 0;
    int bytes_checked = 0;

    usb_control_endpoint_responder #(
        .MAX_PACKET(EP0_PKT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [7:0] device_desc_at(input logic [4:0] pos);
        case (pos)
            5'd0:    return DEV_DESC_LEN;
            5'd1:    return DESC_TYPE_DEVICE;
            5'd2:    return USB_BCD_LO;
            5'd3:    return USB_BCD_HI;
            5'd7:    return EP0_MAX_SIZE;
            5'd8:    return ep_vid[7:0];
            5'd9:    return ep_vid[15:8];
            5'd10:   return ep_pid[7:0];
            5'd11:   return ep_pid[15:8];
            5'd12:   return ep_rel[7:0];
            5'd13:   return ep_rel[15:8];
            5'd17:   return NUM_CONFIGS;
            default: return 8'd0;
        endcase
    endfunction

    // Reflected CRC16, processed one bit at a time from the least significant end.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic t_tx_byte tx_entry(input logic [7:0] b, input logic last,
                                          input logic [3:0] plen);
        t_tx_byte e;
        e.tx_byte = b;
        e.last = last;
        e.plen = plen;
        e.addr = pend_addr;
        e.cfgv = conf_val;
        return e;
    endfunction

    task automatic predict_request(input t_item it);
        logic [7:0]  reply;
        logic [7:0]  want;
        logic [7:0]  b;
        logic [15:0] crc;
        logic [3:0]  plen;
        case (it.func)
            FUNC_RX: begin
                if (it.is_setup_token && it.data_len == SETUP_LEN) begin
                    reply = 8'd0;
                    data_pid = PID_DATA0;
                    if (it.request_type[6:5] == 2'b00) begin
                        if (it.request_code == REQ_SET_ADDRESS) begin
                            pend_addr = it.value_low;
                        end else if (it.request_code == REQ_SET_CONFIG) begin
                            conf_val = it.value_low;
                        end else if (it.request_code == REQ_GET_DESCRIPTOR &&
                                     it.value_high == DESC_TYPE_DEVICE) begin
                            reply = DEV_DESC_LEN;
                            desc_pos = 5'd0;
                        end
                    end
                    if (it.length_high == 8'd0 && reply > it.length_low) begin
                        reply = it.length_low;
                    end
                    msg_left = reply;
                end
            end
            FUNC_TXFREE: begin
                if (msg_left != NO_MSG) begin
                    want = (msg_left > EP0_PKT) ? 8'(EP0_PKT) : msg_left;
                    msg_left = msg_left - want;
                    data_pid = data_pid ^ (PID_DATA0 ^ PID_DATA1);
                    plen = want[3:0] + PKT_OVERHEAD;
                    tx_due.push_back(tx_entry(data_pid, 1'b0, plen));
                    crc = CRC_INIT;
                    for (int i = 0; i < want; i++) begin
                        b = device_desc_at(desc_pos);
                        desc_pos = desc_pos + 5'd1;
                        crc = crc16_update(crc, b);
                        tx_due.push_back(tx_entry(b, 1'b0, plen));
                    end
                    crc = ~crc;
                    tx_due.push_back(tx_entry(crc[7:0], 1'b0, plen));
                    tx_due.push_back(tx_entry(crc[15:8], 1'b1, plen));
                    // A short packet closes the message; a full one leaves it open.
                    if (want < EP0_PKT) begin
                        msg_left = NO_MSG;
                    end
                    packets_due++;
                end
            end
            FUNC_BUSRST: begin
                pend_addr = 8'd0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, exp_val, $time);
        errors++;
    endtask

    // Request driver: takes the next pending request when the slot is free, unless the random idle draw holds it back.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_request(in_flight);
                accepted++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = pending_requests.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {4'd0, in_flight.length_high, in_flight.length_low,
                                  in_flight.value_high, in_flight.value_low,
                                  in_flight.request_code, in_flight.request_type,
                                  in_flight.data_len};
                    i_s_tuser <= {in_flight.is_setup_token, in_flight.func};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Packet byte monitor.
    always @(posedge i_clk) begin
        t_tx_byte got;
        t_tx_byte exp_b;
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.tx_byte = o_m_tdata[7:0];
            got.last = o_m_tlast;
            got.plen = o_m_tdata[11:8];
            got.addr = o_m_tdata[19:12];
            got.cfgv = o_m_tdata[27:20];
            if (tx_due.size() == 0) begin
                report_mismatch("byte with nothing pending", 16'(got.tx_byte), 16'd0);
            end else begin
                exp_b = tx_due.pop_front();
                if (got.tx_byte != exp_b.tx_byte)
                    report_mismatch("tx_byte", 16'(got.tx_byte), 16'(exp_b.tx_byte));
                if (got.last != exp_b.last)
                    report_mismatch("tlast", 16'(got.last), 16'(exp_b.last));
                if (got.plen != exp_b.plen)
                    report_mismatch("packet_len", 16'(got.plen), 16'(exp_b.plen));
                if (got.addr != exp_b.addr)
                    report_mismatch("pending_address", 16'(got.addr), 16'(exp_b.addr));
                if (got.cfgv != exp_b.cfgv)
                    report_mismatch("configuration", 16'(got.cfgv), 16'(exp_b.cfgv));
                bytes_checked++;
            end
        end
    end

    function automatic t_item mk_setup(input logic [7:0] rtype, input logic [7:0] code,
                                       input logic [7:0] vlo, input logic [7:0] vhi,
                                       input logic [7:0] llo, input logic [7:0] lhi);
        t_item it;
        it.func = FUNC_RX;
        it.is_setup_token = 1'b1;
        it.data_len = SETUP_LEN;
        it.request_type = rtype;
        it.request_code = code;
        it.value_low = vlo;
        it.value_high = vhi;
        it.length_low = llo;
        it.length_high = lhi;
        return it;
    endfunction

    function automatic t_item mk_event(input logic [1:0] f);
        t_item it;
        it = mk_setup(RT_STD_OUT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        it.func = f;
        it.is_setup_token = 1'b0;
        it.data_len = 4'd0;
        return it;
    endfunction

    function automatic t_item rand_setup();
        t_item       it;
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [7:0]  vhi;
        logic [7:0]  llo;
        logic [7:0]  lhi;
        logic [31:0] r;
        r = $urandom;
        // Mostly standard requests, direction bit and recipient bits random.
        case ($urandom_range(5))
            0:       rtype = 8'($urandom);
            1:       rtype = ($urandom_range(1) != 0) ? RT_CLASS : RT_VENDOR;
            default: rtype = {r[7], 2'b00, r[4:0]};
        endcase
        case ($urandom_range(7))
            0, 1:    code = REQ_SET_ADDRESS;
            2:       code = REQ_SET_CONFIG;
            3:       code = 8'($urandom);
            default: code = REQ_GET_DESCRIPTOR;
        endcase
        vhi = ($urandom_range(4) != 0) ? DESC_TYPE_DEVICE : 8'($urandom);
        case ($urandom_range(3))
            0:       llo = 8'($urandom);
            1:       llo = 8'hFF;
            default: llo = 8'($urandom_range(24));
        endcase
        lhi = ($urandom_range(4) == 0) ? 8'($urandom) : 8'd0;
        it = mk_setup(rtype, code, 8'($urandom), vhi, llo, lhi);
        if ($urandom_range(9) == 0) begin
            it.is_setup_token = 1'($urandom);
            it.data_len = 4'($urandom);
        end
        return it;
    endfunction

    task automatic queue_random_traffic(input int n);
        int    made;
        int    burst;
        t_item it;
        made = 0;
        while (made < n) begin
            case ($urandom_range(9))
                0: begin
                    // Noise: every field random, most of it ignored by the block.
                    it.func = 2'($urandom);
                    it.is_setup_token = 1'($urandom);
                    it.data_len = 4'($urandom);
                    it.request_type = 8'($urandom);
                    it.request_code = 8'($urandom);
                    it.value_low = 8'($urandom);
                    it.value_high = 8'($urandom);
                    it.length_low = 8'($urandom);
                    it.length_high = 8'($urandom);
                    pending_requests.push_back(it);
                    ignored_made++;
                end
                1: begin
                    pending_requests.push_back(mk_event(FUNC_BUSRST));
                    made++;
                end
                default: begin
                    pending_requests.push_back(rand_setup());
                    made++;
                    burst = $urandom_range(4);
                    repeat (burst) pending_requests.push_back(mk_event(FUNC_TXFREE));
                    made += burst;
                end
            endcase
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || i_s_tvalid || tx_due.size() != 0)
            @(negedge i_clk);
        // Requests without a reply may still be in the sequencer.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_VENDOR_ID:      ep_vid = val;
            REG_PRODUCT_ID:     ep_pid = val;
            REG_DEVICE_RELEASE: ep_rel = val;
            default: begin
            end
        endcase
    endtask

    initial begin
        t_item it;
        ep_vid = VENDOR_ID_RESET;
        ep_pid = PRODUCT_ID_RESET;
        ep_rel = DEVICE_RELEASE_RESET;
        pend_addr = 8'd0;
        conf_val = 8'd0;
        msg_left = NO_MSG;
        desc_pos = 5'd0;
        data_pid = PID_DATA0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests with the reset descriptor IDs and no idling.
        pending_requests.push_back(mk_event(FUNC_TXFREE));
        pending_requests.push_back(mk_event(FUNC_SPARE));
        pending_requests.push_back(mk_setup(RT_STD_OUT, REQ_SET_ADDRESS, 8'hFF, 8'h00,
                                            8'h00, 8'h00));
        pending_requests.push_back(mk_event(FUNC_TXFREE));
        pending_requests.push_back(mk_setup(RT_STD_OUT, REQ_SET_CONFIG, 8'h01, 8'hFF,
                                            8'hFF, 8'hFF));
        pending_requests.push_back(mk_event(FUNC_TXFREE));
        pending_requests.push_back(mk_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, 8'h00,
                                            DESC_TYPE_DEVICE, 8'hFF, 8'h00));
        repeat (4) pending_requests.push_back(mk_event(FUNC_TXFREE));
        pending_requests.push_back(mk_event(FUNC_BUSRST));
        // A message that ends exactly on a full packet needs an empty packet after it.
        pending_requests.push_back(mk_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, 8'h00,
                                            DESC_TYPE_DEVICE, 8'd8, 8'h00));
        repeat (2) pending_requests.push_back(mk_event(FUNC_TXFREE));
        pending_requests.push_back(mk_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, 8'h00,
                                            DESC_TYPE_DEVICE, 8'h00, 8'h01));
        pending_requests.push_back(mk_event(FUNC_TXFREE));
        pending_requests.push_back(mk_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, 8'h00,
                                            DESC_TYPE_CONFIG, 8'hFF, 8'h00));
        pending_requests.push_back(mk_event(FUNC_TXFREE));
        pending_requests.push_back(mk_setup(RT_VENDOR, REQ_SET_ADDRESS, 8'h55, 8'h00,
                                            8'h00, 8'h00));
        pending_requests.push_back(mk_event(FUNC_TXFREE));
        it = mk_setup(RT_STD_OUT, REQ_SET_ADDRESS, 8'h77, 8'h00, 8'h00, 8'h00);
        it.is_setup_token = 1'b0;
        pending_requests.push_back(it);
        it.is_setup_token = 1'b1;
        it.data_len = 4'hF;
        pending_requests.push_back(it);
        pending_requests.push_back(mk_event(FUNC_TXFREE));
        pending_requests.push_back(mk_setup(RT_STD_IN, REQ_GET_DESCRIPTOR, 8'h00,
                                            DESC_TYPE_DEVICE, 8'h00, 8'h00));
        pending_requests.push_back(mk_event(FUNC_TXFREE));
        settle();

        write_reg(REG_VENDOR_ID, 16'h0000);
        write_reg(REG_PRODUCT_ID, 16'hFFFF);
        write_reg(REG_DEVICE_RELEASE, 16'($urandom));
        queue_random_traffic(RANDOM_PER_PHASE);
        settle();

        send_idle_pct = 78;
        write_reg(REG_VENDOR_ID, 16'hFFFF);
        write_reg(REG_PRODUCT_ID, 16'h0000);
        write_reg(REG_DEVICE_RELEASE, 16'h0000);
        queue_random_traffic(RANDOM_PER_PHASE);
        settle();

        send_idle_pct = 0;
        recv_stall_pct = 78;
        write_reg(REG_VENDOR_ID, 16'($urandom));
        write_reg(REG_PRODUCT_ID, 16'($urandom));
        write_reg(REG_DEVICE_RELEASE, 16'hFFFF);
        queue_random_traffic(RANDOM_PER_PHASE);
        settle();

        send_idle_pct = 30;
        recv_stall_pct = 30;
        write_reg(REG_VENDOR_ID, 16'($urandom));
        write_reg(REG_PRODUCT_ID, 16'($urandom));
        write_reg(REG_DEVICE_RELEASE, 16'($urandom));
        queue_random_traffic(RANDOM_PER_PHASE);
        settle();

        $display("Covered %0d requests and events (%0d random noise) across four idle mixes",
                 accepted, ignored_made);
        $display("and five descriptor ID settings; %0d IN packets, %0d bytes, %0d mismatches",
                 packets_due, bytes_checked, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out waiting for the endpoint to finish");
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/usbcep_pkg.sv
design/usbcep_seq.sv
design/usbcep_dp.sv
design/usb_control_endpoint_responder.sv
tb/sv/usb_control_endpoint_responder_tb.sv
